>>> rtl/fmx_pkg.sv
// shared types, sizes and helpers for the fifo with max search and swap
// no dependencies; imported by every module of the block
package fmx_pkg;

  localparam int DEPTH       = 16;
  localparam int PTR_W       = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int VAL_W       = 32;
  localparam int KIND_W      = 2;
  localparam int IN_TDATA_W  = ((VAL_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;
  localparam int OCC_LSB     = VAL_W;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic signed [VAL_W-1:0] val_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH    = 2'd0,
    KIND_POP     = 2'd1,
    KIND_REPLACE = 2'd2,
    KIND_SWAP    = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_RD,
    ST_SCAN,
    ST_SCAN_TAIL,
    ST_LAST,
    ST_WB_TAIL,
    ST_RESP
  } state_t;

  // control from the sequencer to the shared compare unit
  typedef struct packed {
    logic en;
    logic first;
  } scan_ctl_t;

  function automatic ptr_t wrap_next(input ptr_t p);
    return (p == PTR_W'(DEPTH - 1)) ? '0 : ptr_t'(p + 1'b1);
  endfunction

  function automatic ptr_t wrap_prev(input ptr_t p);
    return (p == '0) ? PTR_W'(DEPTH - 1) : ptr_t'(p - 1'b1);
  endfunction

endpackage

>>> rtl/fifo_with_max_swap.sv
// fifo of signed 32-bit values in a 16-entry ring, with max replace and max swap
// one request at a time: a new request is taken only after the previous result is loaded
// into the output register, which out_tready stalls can hold up
// in_tready low while busy; the scan reads one ring entry per cycle through the single read port
// reset (rst_n low, synchronous): queue empty, pointers zero, no result pending
// depends on fmx_pkg and fmx_scan
module fifo_with_max_swap (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [fmx_pkg::IN_TDATA_W-1:0] in_tdata,   // [31:0] push_value
  input  logic [fmx_pkg::KIND_W-1:0]     in_tuser,   // [1:0] kind
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [fmx_pkg::OUT_TDATA_W-1:0] out_tdata, // [31:0] pop_value, [36:32] occupancy
  output logic [0:0]                     out_tuser   // [0] ok
);
  import fmx_pkg::*;

  // ring storage, written and read in one clocked block
  val_t mem [DEPTH];
  val_t rd_data_r;
  ptr_t rd_slot_r;
  ptr_t rd_addr;
  logic mem_we;
  ptr_t mem_wa;
  val_t mem_wd;

  // sequencer and queue state
  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  ptr_t   head_r, head_nxt;
  ptr_t   tail_r, tail_nxt;
  cnt_t   cnt_r, cnt_nxt;

  // scan bookkeeping
  ptr_t scan_slot_r, scan_slot_nxt;
  cnt_t scan_left_r, scan_left_nxt;
  logic scan_rd_r, scan_rd_nxt;
  logic scan_first_r, scan_first_nxt;
  scan_ctl_t scan_ctl;
  val_t best_val;
  ptr_t best_slot;

  // result of the request in flight
  logic res_ok_r, res_ok_nxt;
  val_t res_pop_r, res_pop_nxt;

  // output register
  logic out_valid_r, out_valid_nxt;
  logic out_ok_r;
  val_t out_pop_r;
  cnt_t out_occ_r;
  logic out_load;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    rd_data_r <= mem[rd_addr];
    rd_slot_r <= rd_addr;
  end

  fmx_scan u_scan (
    .clk       (clk),
    .ctl       (scan_ctl),
    .data      (rd_data_r),
    .slot      (rd_slot_r),
    .best_val  (best_val),
    .best_slot (best_slot)
  );

  // a read issued last cycle during the scan feeds the compare unit now
  assign scan_ctl.en    = scan_rd_r;
  assign scan_ctl.first = scan_first_r;

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    cnt_nxt        = cnt_r;
    scan_slot_nxt  = scan_slot_r;
    scan_left_nxt  = scan_left_r;
    scan_rd_nxt    = 1'b0;
    scan_first_nxt = scan_rd_r ? 1'b0 : scan_first_r;
    res_ok_nxt     = res_ok_r;
    res_pop_nxt    = res_pop_r;
    rd_addr        = head_r;
    mem_we         = 1'b0;
    mem_wa         = tail_r;
    mem_wd         = best_val;
    out_load       = 1'b0;
    in_tready      = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          kind_nxt    = kind_t'(in_tuser);
          res_ok_nxt  = 1'b1;
          res_pop_nxt = '0;
          case (kind_t'(in_tuser))
            KIND_PUSH: begin
              state_nxt = ST_RESP;
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_ok_nxt = 1'b0;  // full: queue untouched
              end else begin
                mem_we   = 1'b1;
                mem_wa   = tail_r;
                mem_wd   = in_tdata[VAL_W-1:0];
                tail_nxt = wrap_next(tail_r);
                cnt_nxt  = cnt_t'(cnt_r + 1'b1);
              end
            end
            KIND_POP: begin
              if (cnt_r == '0) begin
                res_ok_nxt = 1'b0;  // empty: nothing to return
                state_nxt  = ST_RESP;
              end else begin
                rd_addr   = head_r;
                state_nxt = ST_POP_RD;
              end
            end
            default: begin
              if (cnt_r < CNT_W'(2)) begin
                state_nxt = ST_RESP;  // short queue: no change
              end else begin
                // first scan read goes out at the head right away
                rd_addr        = head_r;
                scan_rd_nxt    = 1'b1;
                scan_first_nxt = 1'b1;
                scan_slot_nxt  = wrap_next(head_r);
                scan_left_nxt  = cnt_t'(cnt_r - 1'b1);
                state_nxt      = ST_SCAN;
              end
            end
          endcase
        end
      end

      ST_POP_RD: begin
        res_pop_nxt = rd_data_r;
        head_nxt    = wrap_next(head_r);
        cnt_nxt     = cnt_t'(cnt_r - 1'b1);
        state_nxt   = ST_RESP;
      end

      ST_SCAN: begin
        // one entry read per cycle, compare follows in the next cycle
        rd_addr       = scan_slot_r;
        scan_rd_nxt   = 1'b1;
        scan_slot_nxt = wrap_next(scan_slot_r);
        scan_left_nxt = cnt_t'(scan_left_r - 1'b1);
        if (scan_left_r == CNT_W'(1)) begin
          state_nxt = ST_SCAN_TAIL;
        end
      end

      ST_SCAN_TAIL: begin
        // last compare happens now; fetch the newest entry
        rd_addr   = wrap_prev(tail_r);
        state_nxt = ST_LAST;
      end

      ST_LAST: begin
        mem_we = 1'b1;
        if (kind_r == KIND_SWAP) begin
          mem_wa    = best_slot;
          mem_wd    = rd_data_r;
          state_nxt = ST_WB_TAIL;
        end else begin
          mem_wa    = wrap_prev(tail_r);
          mem_wd    = best_val;
          state_nxt = ST_RESP;
        end
      end

      ST_WB_TAIL: begin
        mem_we    = 1'b1;
        mem_wa    = wrap_prev(tail_r);
        mem_wd    = best_val;
        state_nxt = ST_RESP;
      end

      ST_RESP: begin
        // hand over once the output register is free or being drained
        if (!out_valid_r || out_tready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      head_r       <= '0;
      tail_r       <= '0;
      cnt_r        <= '0;
      scan_rd_r    <= 1'b0;
      scan_first_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      head_r       <= head_nxt;
      tail_r       <= tail_nxt;
      cnt_r        <= cnt_nxt;
      scan_rd_r    <= scan_rd_nxt;
      scan_first_r <= scan_first_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk) begin
    kind_r      <= kind_nxt;
    scan_slot_r <= scan_slot_nxt;
    scan_left_r <= scan_left_nxt;
    res_ok_r    <= res_ok_nxt;
    res_pop_r   <= res_pop_nxt;
    if (out_load) begin
      out_ok_r  <= res_ok_r;
      out_pop_r <= res_pop_r;
      out_occ_r <= cnt_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_ok_r;
  assign out_tdata  = OUT_TDATA_W'({out_occ_r, out_pop_r});

endmodule

>>> rtl/fmx_scan.sv
// shared signed compare unit: keeps the running maximum and its slot
// depends on fmx_pkg
module fmx_scan (
  input  logic              clk,
  input  fmx_pkg::scan_ctl_t ctl,
  input  fmx_pkg::val_t     data,
  input  fmx_pkg::ptr_t     slot,
  output fmx_pkg::val_t     best_val,
  output fmx_pkg::ptr_t     best_slot
);
  import fmx_pkg::*;

  val_t best_val_r;
  ptr_t best_slot_r;
  logic take;

  // strict greater keeps the entry nearest the head on ties
  assign take = ctl.en && (ctl.first || (data > best_val_r));

  always_ff @(posedge clk) begin
    if (take) begin
      best_val_r  <= data;
      best_slot_r <= slot;
    end
  end

  assign best_val  = best_val_r;
  assign best_slot = best_slot_r;

endmodule

>>> rtl/fmx_chk.sv
// port-level checks for fifo_with_max_swap, attached by bind
// depends on fmx_pkg and the top level's port names
module fmx_chk (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_tvalid,
  input logic                            in_tready,
  input logic                            out_tvalid,
  input logic                            out_tready,
  input logic [fmx_pkg::OUT_TDATA_W-1:0] out_tdata,
  input logic [0:0]                      out_tuser
);
  import fmx_pkg::*;

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // one request at a time: busy right after a transfer in
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken while busy");

  // occupancy never beyond the ring size
  a_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OCC_LSB +: CNT_W] <= CNT_W'(DEPTH))
    else $error("occupancy out of range");

  // a failed request returns zero and only happens empty or full
  a_fail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser[0] |-> out_tdata[VAL_W-1:0] == '0 &&
      (out_tdata[OCC_LSB +: CNT_W] == '0 || out_tdata[OCC_LSB +: CNT_W] == CNT_W'(DEPTH)))
    else $error("bad failed result");

endmodule

bind fifo_with_max_swap fmx_chk u_fmx_chk (.*);
